// ===== sv/bag_of_words_indexer_counter_macros.svh =====
// Assertion macros for the bag-of-words indexer and counter
`ifndef BAG_OF_WORDS_INDEXER_COUNTER_MACROS_SVH
`define BAG_OF_WORDS_INDEXER_COUNTER_MACROS_SVH

// Invariant that holds at every clock edge out of reset
`define BOW_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define BOW_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bow_pkg.sv =====
// Constants, types and helpers for the bag-of-words indexer module
package bow_pkg;

    localparam int VOCAB_DEPTH   = 4096;
    localparam int MAX_TOKEN_LEN = 29;
    localparam int COUNT_BITS    = 24;

    localparam int IDX_W  = $clog2(VOCAB_DEPTH);
    localparam int SIZE_W = IDX_W + 1;
    localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int TOK_W  = MAX_TOKEN_LEN * 8;
    localparam int KEY_W  = TOK_W + LEN_W;
    localparam int LST_W  = IDX_W + COUNT_BITS;
    localparam int DOC_W  = 32;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_END  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        K_WORD      = 2'd0,
        K_SUMMARY   = 2'd1,
        K_ENTRY     = 2'd2,
        K_EXHAUSTED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_SOW,
        S_LCHK,
        S_INS,
        S_EMIT_WORD,
        S_EMIT_SUM
    } state_t;

    function automatic logic is_space(input logic [7:0] b);
        return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
    endfunction

endpackage

// ===== sv/bow_if.sv =====
// Item channel interfaces: text input and result output
interface bow_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_byte;

    modport source (output valid, output opcode, output char_byte, input ready);
    modport sink   (input valid, input opcode, input char_byte, output ready);
endinterface

interface bow_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] word_index;
    logic        is_new;
    logic [23:0] word_count;
    logic [12:0] distinct_in_doc;
    logic [12:0] dictionary_size;
    logic [31:0] documents_done;
    logic        dictionary_full;
    logic        last;

    modport source (output valid, output kind, output word_index, output is_new,
                    output word_count, output distinct_in_doc, output dictionary_size,
                    output documents_done, output dictionary_full, output last,
                    input ready);
    modport sink   (input valid, input kind, input word_index, input is_new,
                    input word_count, input distinct_in_doc, input dictionary_size,
                    input documents_done, input dictionary_full, input last,
                    output ready);
endinterface

// ===== sv/bow_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data
module bow_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/bag_of_words_indexer_counter.sv =====
// Bag-of-words indexer: tokenizer, dictionary lookup and per-document counter
//
// Channel tokens carries one item per byte (opcode 0), end of document (opcode 1)
// or a read of the next list entry (opcode 2). Channel results carries results.
// A text byte that extends a token short of the length limit gives no result.
// A completed token runs a linear search of the dictionary memory, a read and a
// compare step per stored word. That search over the single dictionary read port,
// with the slot, list and insert steps, sets the time between token accepts.
// The word result then follows through the slot and list memories.
// End of document gives an optional word result (last = 0) and a summary.
// A read item gives one list entry or an exhausted result.
// The input is taken only while the sequencer is idle; one item is in work at
// a time. Results sit in an output register: the block keeps working while
// one waits, and holds in an emit state when the register is still full.
// Reset empties the dictionary, the open token and the document state; the
// memories need no clearing pass, since membership in the current document is
// checked against the list itself.
`include "bag_of_words_indexer_counter_macros.svh"

module bag_of_words_indexer_counter (
    input  logic          clk,
    input  logic          rst_n,
    bow_in_if.sink        tokens,
    bow_out_if.source     results
);

    localparam logic [bow_pkg::COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [bow_pkg::DOC_W-1:0]      DOC_MAX = '1;
    localparam logic [bow_pkg::SIZE_W-1:0]     VOCAB_FULL =
        bow_pkg::SIZE_W'(bow_pkg::VOCAB_DEPTH);

    bow_pkg::state_t state_reg, state_next;

    logic [bow_pkg::TOK_W-1:0]      tbuf_reg, tbuf_next;
    logic [bow_pkg::LEN_W-1:0]      tlen_reg, tlen_next;
    logic [bow_pkg::SIZE_W-1:0]     used_reg, used_next;
    logic [bow_pkg::SIZE_W-1:0]     distinct_reg, distinct_next;
    logic [bow_pkg::SIZE_W-1:0]     rp_reg, rp_next;
    logic [bow_pkg::DOC_W-1:0]      docs_reg, docs_next;
    logic                           fin_reg, fin_next;
    logic                           pend_reg, pend_next;
    logic                           hit_reg, hit_next;
    logic                           rd_reg, rd_next;
    logic [bow_pkg::SIZE_W-1:0]     scan_reg, scan_next;
    logic [bow_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [bow_pkg::IDX_W-1:0]      slot_reg, slot_next;
    logic                           new_reg, new_next;
    logic                           full_reg, full_next;
    logic [bow_pkg::COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic                           ov_reg, ov_next;
    logic [1:0]                     okind_reg, okind_next;
    logic [bow_pkg::IDX_W-1:0]      oidx_reg, oidx_next;
    logic                           onew_reg, onew_next;
    logic [bow_pkg::COUNT_BITS-1:0] ocnt_reg, ocnt_next;
    logic [bow_pkg::SIZE_W-1:0]     odist_reg, odist_next;
    logic [bow_pkg::SIZE_W-1:0]     osize_reg, osize_next;
    logic [bow_pkg::DOC_W-1:0]      odocs_reg, odocs_next;
    logic                           ofull_reg, ofull_next;
    logic                           olast_reg, olast_next;

    logic                           accept, out_free, space, key_match, in_doc;
    logic [bow_pkg::DOC_W-1:0]      docs_inc;
    logic [bow_pkg::LST_W-1:0]      lst_entry;

    logic                           dict_we, dict_re;
    logic [bow_pkg::IDX_W-1:0]      dict_waddr, dict_raddr;
    logic [bow_pkg::KEY_W-1:0]      dict_rdata;
    logic                           sow_we, sow_re;
    logic [bow_pkg::IDX_W-1:0]      sow_waddr, sow_raddr, sow_wdata, sow_rdata;
    logic                           lst_we, lst_re;
    logic [bow_pkg::IDX_W-1:0]      lst_waddr, lst_raddr;
    logic [bow_pkg::LST_W-1:0]      lst_wdata, lst_rdata;

    bow_ram #(.WIDTH(bow_pkg::KEY_W), .DEPTH(bow_pkg::VOCAB_DEPTH)) u_dict (
        .clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata({tlen_reg, tbuf_reg}),
        .re(dict_re), .raddr(dict_raddr), .rdata(dict_rdata)
    );

    bow_ram #(.WIDTH(bow_pkg::IDX_W), .DEPTH(bow_pkg::VOCAB_DEPTH)) u_slot (
        .clk(clk), .we(sow_we), .waddr(sow_waddr), .wdata(sow_wdata),
        .re(sow_re), .raddr(sow_raddr), .rdata(sow_rdata)
    );

    bow_ram #(.WIDTH(bow_pkg::LST_W), .DEPTH(bow_pkg::VOCAB_DEPTH)) u_list (
        .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
        .re(lst_re), .raddr(lst_raddr), .rdata(lst_rdata)
    );

    assign tokens.ready = (state_reg == bow_pkg::S_IDLE);
    assign accept       = tokens.valid && tokens.ready;
    assign out_free     = !ov_reg || results.ready;
    assign space        = bow_pkg::is_space(tokens.char_byte);
    assign key_match    = (dict_rdata == {tlen_reg, tbuf_reg});
    assign in_doc       = ({1'b0, slot_reg} < distinct_reg) &&
                          (lst_rdata[bow_pkg::LST_W-1:bow_pkg::COUNT_BITS] == idx_reg);
    assign docs_inc     = (docs_reg != DOC_MAX) ? docs_reg + 1'b1 : docs_reg;
    assign lst_entry    = {idx_reg, bow_pkg::COUNT_BITS'(1)};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bow_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (bow_pkg::op_t'(tokens.opcode))
                        bow_pkg::OP_BYTE:
                        begin
                            if (space)
                            begin
                                if (tlen_reg != '0)
                                begin
                                    state_next = bow_pkg::S_SCAN;
                                end
                            end
                            else if (32'(tlen_reg) + 1 >= bow_pkg::MAX_TOKEN_LEN)
                            begin
                                state_next = bow_pkg::S_SCAN;
                            end
                        end
                        bow_pkg::OP_END:
                        begin
                            state_next = (tlen_reg != '0) ? bow_pkg::S_SCAN
                                                          : bow_pkg::S_EMIT_SUM;
                        end
                        bow_pkg::OP_READ:
                        begin
                            state_next = bow_pkg::S_EMIT_WORD;
                        end
                        bow_pkg::OP_NONE:
                        begin
                            state_next = bow_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            bow_pkg::S_SCAN:
            begin
                if (scan_reg == used_reg)
                begin
                    state_next = (used_reg == VOCAB_FULL) ? bow_pkg::S_EMIT_WORD
                                                          : bow_pkg::S_INS;
                end
                else
                begin
                    state_next = bow_pkg::S_CMP;
                end
            end
            bow_pkg::S_CMP:
            begin
                state_next = key_match ? bow_pkg::S_SOW : bow_pkg::S_SCAN;
            end
            bow_pkg::S_SOW:
            begin
                state_next = bow_pkg::S_LCHK;
            end
            bow_pkg::S_LCHK:
            begin
                state_next = in_doc ? bow_pkg::S_EMIT_WORD : bow_pkg::S_INS;
            end
            bow_pkg::S_INS:
            begin
                state_next = bow_pkg::S_EMIT_WORD;
            end
            bow_pkg::S_EMIT_WORD:
            begin
                if (out_free)
                begin
                    state_next = pend_reg ? bow_pkg::S_EMIT_SUM : bow_pkg::S_IDLE;
                end
            end
            bow_pkg::S_EMIT_SUM:
            begin
                if (out_free)
                begin
                    state_next = bow_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bow_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        tbuf_next     = tbuf_reg;
        tlen_next     = tlen_reg;
        used_next     = used_reg;
        distinct_next = distinct_reg;
        rp_next       = rp_reg;
        docs_next     = docs_reg;
        fin_next      = fin_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        rd_next       = rd_reg;
        scan_next     = scan_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        new_next      = new_reg;
        full_next     = full_reg;
        cnt_next      = cnt_reg;

        ov_next    = ov_reg && !results.ready;
        okind_next = okind_reg;
        oidx_next  = oidx_reg;
        onew_next  = onew_reg;
        ocnt_next  = ocnt_reg;
        odist_next = odist_reg;
        osize_next = osize_reg;
        odocs_next = odocs_reg;
        ofull_next = ofull_reg;
        olast_next = olast_reg;

        dict_we    = 1'b0;
        dict_waddr = used_reg[bow_pkg::IDX_W-1:0];
        dict_re    = 1'b0;
        dict_raddr = scan_reg[bow_pkg::IDX_W-1:0];
        sow_we     = 1'b0;
        sow_waddr  = idx_reg;
        sow_wdata  = distinct_reg[bow_pkg::IDX_W-1:0];
        sow_re     = 1'b0;
        sow_raddr  = scan_reg[bow_pkg::IDX_W-1:0];
        lst_we     = 1'b0;
        lst_waddr  = distinct_reg[bow_pkg::IDX_W-1:0];
        lst_wdata  = lst_entry;
        lst_re     = 1'b0;
        lst_raddr  = sow_rdata;

        unique case (state_reg)
            bow_pkg::S_IDLE:
            begin
                scan_next = '0;
                new_next  = 1'b0;
                full_next = 1'b0;
                if (accept)
                begin
                    // a byte or end item after a finished document opens a new one
                    if ((tokens.opcode == bow_pkg::OP_BYTE || tokens.opcode == bow_pkg::OP_END)
                        && fin_reg)
                    begin
                        distinct_next = '0;
                        rp_next       = '0;
                        fin_next      = 1'b0;
                    end
                    if (tokens.opcode == bow_pkg::OP_BYTE && !space)
                    begin
                        tbuf_next[8*tlen_reg +: 8] = tokens.char_byte;
                        tlen_next                  = tlen_reg + 1'b1;
                    end
                    pend_next = (tokens.opcode == bow_pkg::OP_END);
                    rd_next   = (tokens.opcode == bow_pkg::OP_READ);
                    if (tokens.opcode == bow_pkg::OP_READ)
                    begin
                        hit_next  = fin_reg && (rp_reg < distinct_reg);
                        lst_re    = 1'b1;
                        lst_raddr = rp_reg[bow_pkg::IDX_W-1:0];
                    end
                    else
                    begin
                        hit_next = 1'b0;
                    end
                end
            end
            bow_pkg::S_SCAN:
            begin
                if (scan_reg == used_reg)
                begin
                    if (used_reg == VOCAB_FULL)
                    begin
                        idx_next  = '0;
                        cnt_next  = '0;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        dict_we   = 1'b1;
                        idx_next  = used_reg[bow_pkg::IDX_W-1:0];
                        used_next = used_reg + 1'b1;
                        new_next  = 1'b1;
                    end
                end
                else
                begin
                    dict_re = 1'b1;
                end
            end
            bow_pkg::S_CMP:
            begin
                if (key_match)
                begin
                    idx_next = scan_reg[bow_pkg::IDX_W-1:0];
                    sow_re   = 1'b1;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            bow_pkg::S_SOW:
            begin
                slot_next = sow_rdata;
                lst_re    = 1'b1;
            end
            bow_pkg::S_LCHK:
            begin
                if (in_doc)
                begin
                    cnt_next = lst_rdata[bow_pkg::COUNT_BITS-1:0];
                    if (cnt_next != CNT_MAX)
                    begin
                        cnt_next = cnt_next + 1'b1;
                    end
                    lst_we    = 1'b1;
                    lst_waddr = slot_reg;
                    lst_wdata = {idx_reg, cnt_next};
                end
            end
            bow_pkg::S_INS:
            begin
                lst_we        = 1'b1;
                sow_we        = 1'b1;
                distinct_next = distinct_reg + 1'b1;
                cnt_next      = bow_pkg::COUNT_BITS'(1);
            end
            bow_pkg::S_EMIT_WORD:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    odist_next = distinct_reg;
                    osize_next = used_reg;
                    odocs_next = docs_reg;
                    onew_next  = 1'b0;
                    ofull_next = 1'b0;
                    olast_next = 1'b1;
                    if (rd_reg && hit_reg)
                    begin
                        okind_next = bow_pkg::K_ENTRY;
                        oidx_next  = lst_rdata[bow_pkg::LST_W-1:bow_pkg::COUNT_BITS];
                        ocnt_next  = lst_rdata[bow_pkg::COUNT_BITS-1:0];
                        rp_next    = rp_reg + 1'b1;
                    end
                    else if (rd_reg)
                    begin
                        okind_next = bow_pkg::K_EXHAUSTED;
                        oidx_next  = '0;
                        ocnt_next  = '0;
                    end
                    else
                    begin
                        okind_next = bow_pkg::K_WORD;
                        oidx_next  = idx_reg;
                        onew_next  = new_reg;
                        ocnt_next  = cnt_reg;
                        ofull_next = full_reg;
                        olast_next = !pend_reg;
                        tbuf_next  = '0;
                        tlen_next  = '0;
                    end
                end
            end
            bow_pkg::S_EMIT_SUM:
            begin
                if (out_free)
                begin
                    docs_next  = docs_inc;
                    fin_next   = 1'b1;
                    rp_next    = '0;
                    pend_next  = 1'b0;
                    ov_next    = 1'b1;
                    okind_next = bow_pkg::K_SUMMARY;
                    oidx_next  = '0;
                    onew_next  = 1'b0;
                    ocnt_next  = '0;
                    odist_next = distinct_reg;
                    osize_next = used_reg;
                    odocs_next = docs_inc;
                    ofull_next = 1'b0;
                    olast_next = 1'b1;
                end
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bow_pkg::S_IDLE;
            tbuf_reg     <= '0;
            tlen_reg     <= '0;
            used_reg     <= '0;
            distinct_reg <= '0;
            rp_reg       <= '0;
            docs_reg     <= '0;
            fin_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            rd_reg       <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tbuf_reg     <= tbuf_next;
            tlen_reg     <= tlen_next;
            used_reg     <= used_next;
            distinct_reg <= distinct_next;
            rp_reg       <= rp_next;
            docs_reg     <= docs_next;
            fin_reg      <= fin_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            rd_reg       <= rd_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        new_reg   <= new_next;
        full_reg  <= full_next;
        cnt_reg   <= cnt_next;
        okind_reg <= okind_next;
        oidx_reg  <= oidx_next;
        onew_reg  <= onew_next;
        ocnt_reg  <= ocnt_next;
        odist_reg <= odist_next;
        osize_reg <= osize_next;
        odocs_reg <= odocs_next;
        ofull_reg <= ofull_next;
        olast_reg <= olast_next;
    end

    assign results.valid           = ov_reg;
    assign results.kind            = okind_reg;
    assign results.word_index      = oidx_reg;
    assign results.is_new          = onew_reg;
    assign results.word_count      = ocnt_reg;
    assign results.distinct_in_doc = odist_reg;
    assign results.dictionary_size = osize_reg;
    assign results.documents_done  = odocs_reg;
    assign results.dictionary_full = ofull_reg;
    assign results.last            = olast_reg;

    `BOW_ALWAYS(a_used_bound, used_reg <= VOCAB_FULL, "dictionary count past depth")
    `BOW_ALWAYS(a_distinct_bound, distinct_reg <= used_reg, "more distinct words than dictionary")
    `BOW_ALWAYS(a_token_bound, 32'(tlen_reg) <= bow_pkg::MAX_TOKEN_LEN, "token not cut at limit")
    `BOW_NEXT(a_sum_done, state_reg == bow_pkg::S_EMIT_SUM && out_free,
              fin_reg && ov_reg && okind_reg == bow_pkg::K_SUMMARY, "summary not issued")

endmodule
